// ===== rtl/hash_table_linear_probe_top_macros.svh =====
// ---------------------------------------------------------------------------
// Hash table assertion macros
// Shared concurrent assertion forms for the hash table checker.
// ---------------------------------------------------------------------------
`ifndef HASH_TABLE_LINEAR_PROBE_TOP_MACROS_SVH
`define HASH_TABLE_LINEAR_PROBE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTLP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/htlp_pkg.sv =====
// ---------------------------------------------------------------------------
// Hash table package
// Sizes, codes, token type and hash helpers for the linear probing table.
// ---------------------------------------------------------------------------
package htlp_pkg;

   // SLOTS must be a power of two so that the modulo hash is a mask.
   localparam int SLOTS      = 16;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int KEY_W      = 31;
   localparam int SLOT_OUT_W = 6;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic MODE_MODULO = 1'b0;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_FOUND    = 2'd2,
      ST_ABSENT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             op;
      logic [KEY_W-1:0] key;
   } token_type;

   // Since 16 is one more than a multiple of five, the key modulo five
   // equals the sum of its hex digits modulo five.
   function automatic logic [2:0] key_mod5(input logic [KEY_W-1:0] key);
      logic [31:0] key_x;
      logic [6:0]  sum;
      logic [4:0]  fold;
      logic [4:0]  rem;
      key_x = {1'b0, key};
      sum   = '0;
      for (int n = 0; n < 8; n++) begin
         sum = sum + 7'(key_x[4*n +: 4]);
      end
      fold = 5'(sum[6:4]) + 5'(sum[3:0]);
      priority if (fold >= 5'd20) begin
         rem = fold - 5'd20;
      end else if (fold >= 5'd15) begin
         rem = fold - 5'd15;
      end else if (fold >= 5'd10) begin
         rem = fold - 5'd10;
      end else if (fold >= 5'd5) begin
         rem = fold - 5'd5;
      end else begin
         rem = fold;
      end
      return rem[2:0];
   endfunction

   function automatic logic [SLOT_W-1:0] mul_home(input logic [2:0] rem);
      logic [SLOT_W-1:0] home;
      unique case (rem)
         3'd1:    home = SLOT_W'((SLOTS * 1) / 5);
         3'd2:    home = SLOT_W'((SLOTS * 2) / 5);
         3'd3:    home = SLOT_W'((SLOTS * 3) / 5);
         3'd4:    home = SLOT_W'((SLOTS * 4) / 5);
         default: home = '0;
      endcase
      return home;
   endfunction

endpackage

// ===== rtl/htlp_req_if.sv =====
// ---------------------------------------------------------------------------
// Hash table request interface
// Valid/ready channel that carries one operation word.
// ---------------------------------------------------------------------------
interface htlp_req_if
   import htlp_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [KEY_W-1:0] key;

   modport source (output valid, output opcode, output key, input ready);
   modport sink   (input valid, input opcode, input key, output ready);
endinterface

// ===== rtl/htlp_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Hash table response interface
// Valid/ready channel that carries one result word.
// ---------------------------------------------------------------------------
interface htlp_rsp_if
   import htlp_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [SLOT_OUT_W-1:0] slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== rtl/htlp_cell.sv =====
// ---------------------------------------------------------------------------
// Hash table cell
// One slot of the table; tests a passing probe and hands it to the next slot.
// ---------------------------------------------------------------------------
module htlp_cell
   import htlp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_in,
   output token_type tok_out,
   output logic      hit
);

   logic [KEY_W-1:0] entry_ff;
   logic [KEY_W-1:0] entry_in;
   token_type        tok_ff;
   logic             match;

   always_comb begin
      match    = (tok_ff.op == OP_INSERT) ? (entry_ff == '0) : (entry_ff == tok_ff.key);
      hit      = tok_ff.valid && match;
      tok_out  = tok_ff;
      tok_out.valid = tok_ff.valid && !match;
      entry_in = (hit && tok_ff.op == OP_INSERT) ? tok_ff.key : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         tok_ff   <= '0;
      end else begin
         entry_ff <= entry_in;
         tok_ff   <= tok_in;
      end
   end

endmodule

// ===== rtl/htlp_ctrl.sv =====
// ---------------------------------------------------------------------------
// Hash table controller
// Takes requests, computes the home slot, launches the probe and returns
// the result through an output register.
// ---------------------------------------------------------------------------
module htlp_ctrl
   import htlp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   htlp_req_if.sink          req,
   htlp_rsp_if.source        rsp,
   output token_type         inj_tok,
   output logic [SLOT_W-1:0] inj_home,
   input  logic [SLOTS-1:0]  hit_vec,
   input  logic              miss
);

   state_type             state_ff;
   state_type             state_in;
   logic                  op_ff;
   logic [KEY_W-1:0]      key_ff;
   logic                  mode_ff;
   status_type            res_status_ff;
   status_type            res_status_in;
   logic [SLOT_W-1:0]     res_slot_ff;
   logic [SLOT_W-1:0]     res_slot_in;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic                  any_hit;
   logic [SLOT_W-1:0]     hit_slot;
   logic                  accept;
   logic                  rsp_load;
   logic                  probe_done;

   always_comb begin
      hit_slot = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit_vec[i]) begin
            hit_slot = hit_slot | SLOT_W'(i);
         end
      end
      any_hit = |hit_vec;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            state_in = S_PROBE;
         end
         S_PROBE: begin
            if (any_hit || miss) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req.ready     = (state_ff == S_IDLE);
      accept        = req.valid && req.ready;
      probe_done    = (state_ff == S_PROBE) && (any_hit || miss);
      rsp_load      = (state_ff == S_FLUSH) && (!rsp_valid_ff || rsp.ready);
      inj_tok.valid = (state_ff == S_HASH);
      inj_tok.op    = op_ff;
      inj_tok.key   = key_ff;
      inj_home      = (mode_ff == MODE_MODULO) ? key_ff[SLOT_W-1:0]
                                               : mul_home(key_mod5(key_ff));
      if (op_ff == OP_INSERT) begin
         res_status_in = any_hit ? ST_INSERTED : ST_FULL;
      end else begin
         res_status_in = any_hit ? ST_FOUND : ST_ABSENT;
      end
      res_slot_in = any_hit ? hit_slot : '0;
      rsp.valid   = rsp_valid_ff;
      rsp.status  = rsp_status_ff;
      rsp.slot    = rsp_slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_MODULO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req.opcode;
         key_ff <= req.key;
      end
      if (probe_done) begin
         res_status_ff <= res_status_in;
         res_slot_ff   <= res_slot_in;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= SLOT_OUT_W'(res_slot_ff);
      end
   end

endmodule

// ===== rtl/hash_table_linear_probe_top.sv =====
// ---------------------------------------------------------------------------
// Hash table with linear probing
// Open-addressing key table built as a row of slot cells.
// ---------------------------------------------------------------------------
// A request word on req_chan carries an opcode (insert or search) and a
// 31-bit key. Each request returns exactly one response word on rsp_chan
// with a status and a slot number. The csr port selects the hash: modulo
// the slot count, or the multiplicative hash with factor 0.2.
// After acceptance the controller computes the home slot in S_HASH, then
// a probe word walks up the row of cells one slot per cycle from home.
// A hit ends the walk, as does a probe that runs past the last slot; the
// result is registered in S_PROBE and moves to the output register on
// rsp_chan in S_FLUSH. The next request word is taken once the result
// has entered the output register, so only one probe is in the row at a
// time and the probe walk sets the length of each operation.
// Reset empties every slot, selects the modulo hash and drops any pending
// response. While rsp_chan is stalled the response word holds; the block
// still takes one new request and finishes its probe, then waits.
// ---------------------------------------------------------------------------
module hash_table_linear_probe_top
   import htlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   htlp_req_if.sink    req_chan,
   htlp_rsp_if.source  rsp_chan
);

   token_type         inj_tok;
   logic [SLOT_W-1:0] inj_home;
   logic [SLOTS-1:0]  hit_vec;
   token_type         tok_in  [SLOTS];
   token_type         tok_out [SLOTS];
   logic              miss;

   htlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .inj_tok   (inj_tok),
      .inj_home  (inj_home),
      .hit_vec   (hit_vec),
      .miss      (miss)
   );

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign tok_in[i] = (inj_tok.valid && inj_home == SLOT_W'(i)) ? inj_tok : '0;
      end else begin : g_rest
         assign tok_in[i] = (inj_tok.valid && inj_home == SLOT_W'(i)) ? inj_tok
                                                                      : tok_out[i-1];
      end

      htlp_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok_in[i]),
         .tok_out (tok_out[i]),
         .hit     (hit_vec[i])
      );
   end

   assign miss = tok_out[SLOTS-1].valid;

endmodule

// ===== rtl/htlp_checker.sv =====
// ---------------------------------------------------------------------------
// Hash table port checker
// Watches the request and response channels of the hash table top level.
// ---------------------------------------------------------------------------
`include "hash_table_linear_probe_top_macros.svh"

module htlp_checker
   import htlp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_status,
   input logic [SLOT_OUT_W-1:0] rsp_slot
);

   `HTLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_slot),
      "Stalled response word changed.")

   `HTLP_ASSERT_SAME(a_miss_slot_zero, clock, reset,
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_ABSENT),
      rsp_slot == '0, "Miss response carries a nonzero slot.")

   `HTLP_ASSERT_SAME(a_hit_slot_range, clock, reset,
      rsp_valid && (rsp_status == ST_INSERTED || rsp_status == ST_FOUND),
      {1'b0, rsp_slot} < (SLOT_OUT_W + 1)'(SLOTS), "Hit response slot out of range.")

   `HTLP_ASSERT_NEXT(a_no_instant_rsp, clock, reset,
      req_valid && req_ready && !rsp_valid,
      !rsp_valid, "Response appeared one cycle after its request.")

endmodule

bind hash_table_linear_probe_top htlp_checker u_htlp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_slot   (rsp_chan.slot)
);
